FILE: hw/rtl/polyphonic_wavetable_synth_macros.svh
// Assertion macros for the wavetable synthesiser.
// Needs no other file; included by modules that check their own logic.
`ifndef POLYPHONIC_WAVETABLE_SYNTH_MACROS_SVH
`define POLYPHONIC_WAVETABLE_SYNTH_MACROS_SVH
`ifndef SYNTHESIS
`define PWS_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PWS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define PWS_ASSERT(label, clk, rst_n, prop, msg)
`define PWS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: hw/rtl/pws_pkg.sv
// Shared types, codes, constants and table functions of the wavetable synthesiser.
// Depends on nothing; compiled first.
`default_nettype none
package pws_pkg;
	localparam int CMD_W = 2;
	localparam int CH_W = 4;
	localparam int KEY_W = 7;
	localparam int VEL_W = 7;
	localparam int PROG_W = 7;
	localparam int SAMPLE_W = 12;
	localparam int WSAMP_W = 16;
	localparam int WAVE_W = 2;
	localparam int KEYS = 128;

	localparam int DEF_NUM_VOICES = 15;
	localparam int DEF_TABLE_LENGTH = 100;
	localparam int DEF_NUM_CHANNELS = 16;

	localparam logic [CMD_W-1:0] CMD_NOTE_ON = 2'd0;
	localparam logic [CMD_W-1:0] CMD_NOTE_OFF = 2'd1;
	localparam logic [CMD_W-1:0] CMD_PROGRAM = 2'd2;
	localparam logic [CMD_W-1:0] CMD_TICK = 2'd3;

	localparam logic [WAVE_W-1:0] WAVE_HYBRID = 2'd0;
	localparam logic [WAVE_W-1:0] WAVE_SINE = 2'd1;
	localparam logic [WAVE_W-1:0] WAVE_SQUARE = 2'd2;

	localparam int PROG_SQUARE = 29;
	localparam int PROG_SINE_LO = 71;
	localparam int PROG_SINE_HI = 79;
	localparam int PROG_SINE2_LO = 52;
	localparam int PROG_SINE2_HI = 54;

	localparam int MIX_SHIFT = 10;
	localparam int MIX_MID = 2048;
	localparam int SAMPLE_MAX = 4095;
	localparam int AMP_FULL = 32767;
	localparam int AMP_HALF = 16383;
	localparam int SCALE_SHIFT = 4;
	localparam int SCALED_W = 20;

	localparam real PI = 3.14159265358979323846;

	typedef struct packed {
		logic valid;
		logic last;
		logic active;
		logic written;
	} pws_ctl_t;

	// phase step of a key, 16.16 table positions per sample at 30 kHz
	function automatic int step_val(int k, int l);
		real f;
		f = 440.0 * (2.0 ** ((real'(k) - 69.0) / 12.0)) * real'(l) * 65536.0 / 30000.0;
		return $rtoi($floor(f));
	endfunction

	function automatic int wave_val(logic [WAVE_W-1:0] kind, int x, int half_len,
		real inv_len);
		real s;
		real t;
		s = $sin(2.0 * PI * real'(x) * inv_len);
		if (kind == WAVE_SINE) begin
			t = real'(AMP_FULL) * s;
		end else if (kind == WAVE_SQUARE) begin
			t = (x < half_len) ? -real'(AMP_FULL) : real'(AMP_FULL);
		end else begin
			t = real'(AMP_HALF) * s + real'(x - half_len) * real'(AMP_HALF) * inv_len;
		end
		return $rtoi(t);
	endfunction

	function automatic logic [WAVE_W-1:0] prog_wave(logic [PROG_W-1:0] p);
		logic [WAVE_W-1:0] w;
		w = WAVE_HYBRID;
		if ((p >= PROG_W'(PROG_SINE_LO) && p <= PROG_W'(PROG_SINE_HI)) ||
		    (p >= PROG_W'(PROG_SINE2_LO) && p <= PROG_W'(PROG_SINE2_HI))) begin
			w = WAVE_SINE;
		end
		if (p == PROG_W'(PROG_SQUARE)) begin
			w = WAVE_SQUARE;
		end
		return w;
	endfunction
endpackage
`default_nettype wire

FILE: hw/rtl/pws_if.sv
// Handshake channels of the synthesiser: command input and sample output.
// Depends on pws_pkg for the field widths.
`default_nettype none
interface pws_cmd_if import pws_pkg::*; ;
	logic valid;
	logic ready;
	logic [CMD_W-1:0] command;
	logic [CH_W-1:0] channel;
	logic [KEY_W-1:0] key;
	logic [VEL_W-1:0] velocity;
	logic [PROG_W-1:0] program_req;
	modport source(output valid, command, channel, key, velocity, program_req, input ready);
	modport sink(input valid, command, channel, key, velocity, program_req, output ready);
endinterface

interface pws_sample_if import pws_pkg::*; ;
	logic valid;
	logic ready;
	logic [SAMPLE_W-1:0] sample;
	modport source(output valid, sample, input ready);
	modport sink(input valid, sample, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/pws_voice_mem.sv
// Voice state memory: one write port with a bit mask, one read port, registered read data.
// Depends on nothing.
`default_nettype none
module pws_voice_mem #(
	parameter int DEPTH = 15,
	parameter int WIDTH = 8
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [WIDTH-1:0] wmask,
	input wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			for (int b = 0; b < WIDTH; b++) begin
				if (wmask[b]) begin
					mem_q[waddr][b] <= wdata[b];
				end
			end
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

FILE: hw/rtl/pws_voice_proc.sv
// Per-voice tick pipeline: phase advance, waveform lookup, decay, scaling, write-back.
// Depends on pws_pkg; fed by the voice memory read port.
`default_nettype none
module pws_voice_proc import pws_pkg::*; #(
	parameter int NUM_VOICES = DEF_NUM_VOICES,
	parameter int TABLE_LENGTH = DEF_TABLE_LENGTH,
	localparam int VIDX_W = NUM_VOICES > 1 ? $clog2(NUM_VOICES) : 1,
	localparam int IDX_W = $clog2(TABLE_LENGTH),
	localparam int PHASE_W = IDX_W + 16,
	localparam int STEP_W = PHASE_W - 1,
	localparam int WORD_W = VEL_W + STEP_W + PHASE_W + WSAMP_W + WAVE_W
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire pws_ctl_t ctl_s1,
	input wire logic [VIDX_W-1:0] vidx_s1,
	input wire logic [WORD_W-1:0] rdata,
	output logic wb_we,
	output logic [VIDX_W-1:0] wb_addr,
	output logic [WORD_W-1:0] wb_data,
	output pws_ctl_t ctl_s4,
	output logic signed [SCALED_W-1:0] scaled_s4
);
	localparam logic [PHASE_W:0] PHASE_TOP = (PHASE_W+1)'(TABLE_LENGTH * 65536);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_LENGTH - 1);
	localparam int HALF_LEN = TABLE_LENGTH / 2;
	localparam real INV_LEN = 1.0 / real'(TABLE_LENGTH);

	logic signed [WSAMP_W-1:0] sine_tab [TABLE_LENGTH];
	logic signed [WSAMP_W-1:0] square_tab [TABLE_LENGTH];
	logic signed [WSAMP_W-1:0] hybrid_tab [TABLE_LENGTH];

	for (genvar x = 0; x < TABLE_LENGTH; x++) begin : g_tab
		assign sine_tab[x] = WSAMP_W'(wave_val(WAVE_SINE, x, HALF_LEN, INV_LEN));
		assign square_tab[x] = WSAMP_W'(wave_val(WAVE_SQUARE, x, HALF_LEN, INV_LEN));
		assign hybrid_tab[x] = WSAMP_W'(wave_val(WAVE_HYBRID, x, HALF_LEN, INV_LEN));
	end

	logic [VEL_W-1:0] vol_f;
	logic [STEP_W-1:0] step_f;
	logic [PHASE_W-1:0] phase_f;
	logic signed [WSAMP_W-1:0] last_f;
	logic [WAVE_W-1:0] wave_f;
	logic [PHASE_W:0] phase_sum;
	logic [PHASE_W:0] phase_wrap;
	logic [IDX_W-1:0] idx_raw;

	assign {vol_f, step_f, phase_f, last_f, wave_f} = ctl_s1.written ? rdata : '0;
	assign phase_sum = {1'b0, phase_f} + {2'b00, step_f};
	assign phase_wrap = (phase_sum >= PHASE_TOP) ? phase_sum - PHASE_TOP : phase_sum;
	assign idx_raw = phase_wrap[PHASE_W-1:16];

	pws_ctl_t ctl_s2, ctl_s3;
	logic [VIDX_W-1:0] vidx_s2, vidx_s3;
	logic [VEL_W-1:0] volm_s2, volw_s2, volm_s3, volw_s3;
	logic [STEP_W-1:0] step_s2, step_s3;
	logic [PHASE_W-1:0] phase_s2, phase_s3;
	logic signed [WSAMP_W-1:0] last_s2, samp_s3;
	logic [WAVE_W-1:0] wave_s2, wave_s3;
	logic [IDX_W-1:0] idx_s2;
	logic signed [WSAMP_W+VEL_W:0] prod;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
		end else begin
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
		end
	end

	always_ff @(posedge clk) begin
		vidx_s2 <= vidx_s1;
		volm_s2 <= vol_f;
		volw_s2 <= (ctl_s1.active || vol_f == '0) ? vol_f : vol_f - VEL_W'(1);
		step_s2 <= step_f;
		phase_s2 <= ctl_s1.active ? phase_wrap[PHASE_W-1:0] : phase_f;
		idx_s2 <= (idx_raw > IDX_LAST) ? IDX_LAST : idx_raw;
		last_s2 <= last_f;
		wave_s2 <= wave_f;

		vidx_s3 <= vidx_s2;
		volm_s3 <= volm_s2;
		volw_s3 <= volw_s2;
		step_s3 <= step_s2;
		phase_s3 <= phase_s2;
		wave_s3 <= wave_s2;
		if (!ctl_s2.active) begin
			samp_s3 <= last_s2;
		end else begin
			case (wave_s2)
				WAVE_SINE: samp_s3 <= sine_tab[idx_s2];
				WAVE_SQUARE: samp_s3 <= square_tab[idx_s2];
				default: samp_s3 <= hybrid_tab[idx_s2];
			endcase
		end

		scaled_s4 <= SCALED_W'(prod >>> SCALE_SHIFT);
	end

	assign prod = samp_s3 * $signed({1'b0, volm_s3});
	assign wb_we = ctl_s3.valid && ctl_s3.written;
	assign wb_addr = vidx_s3;
	assign wb_data = {volw_s3, step_s3, phase_s3, samp_s3, wave_s3};
endmodule
`default_nettype wire

FILE: hw/rtl/polyphonic_wavetable_synth.sv
// Top level of the wavetable synthesiser: command sequencer, voice allocation, mix.
// Depends on pws_pkg, pws_if, pws_voice_mem, pws_voice_proc and the assertion macros.
//
// Note on, note off and program change do not leave the idle state, so the block
// stays ready for the next command. A sample tick reads the voice memory, which has
// one read port, so one voice enters the four-stage tick pipeline per cycle, then
// the pipeline drains and the mix is clamped into the output register. The sample
// waits there until taken; the next command is accepted meanwhile. A following tick
// runs through its voices and then holds in its final state, with no command
// accepted, until the previous sample has been taken.
`default_nettype none
`include "polyphonic_wavetable_synth_macros.svh"
module polyphonic_wavetable_synth import pws_pkg::*; #(
	parameter int NUM_VOICES = DEF_NUM_VOICES,
	parameter int TABLE_LENGTH = DEF_TABLE_LENGTH,
	parameter int NUM_CHANNELS = DEF_NUM_CHANNELS
) (
	input wire logic clk,
	input wire logic arst_n,
	pws_cmd_if.sink cmd,
	pws_sample_if.source result
);
	localparam int VIDX_W = NUM_VOICES > 1 ? $clog2(NUM_VOICES) : 1;
	localparam int CHI_W = NUM_CHANNELS > 1 ? $clog2(NUM_CHANNELS) : 1;
	localparam int IDX_W = $clog2(TABLE_LENGTH);
	localparam int PHASE_W = IDX_W + 16;
	localparam int STEP_W = PHASE_W - 1;
	localparam int WORD_W = VEL_W + STEP_W + PHASE_W + WSAMP_W + WAVE_W;
	localparam int ACC_W = SCALED_W + $clog2(NUM_VOICES + 1);
	localparam logic [VIDX_W-1:0] VIDX_LAST = VIDX_W'(NUM_VOICES - 1);
	localparam logic signed [ACC_W-1:0] MID_S = ACC_W'(MIX_MID);
	localparam logic signed [ACC_W-1:0] MAX_S = ACC_W'(SAMPLE_MAX);
	localparam logic [WORD_W-1:0] LAST_MASK = {{(WORD_W - WSAMP_W - WAVE_W){1'b0}},
	                                           {WSAMP_W{1'b1}}, {WAVE_W{1'b0}}};

	typedef enum logic [1:0] {S_IDLE, S_TICK, S_DRAIN, S_FIN} state_t;

	state_t state_q;
	logic [VIDX_W-1:0] rd_idx_q;
	logic res_valid_q;
	logic [SAMPLE_W-1:0] res_sample_q;
	logic [NUM_VOICES-1:0] active_q, written_q;
	logic [KEY_W-1:0] note_q [NUM_VOICES];
	logic [WAVE_W-1:0] chan_wave_q [NUM_CHANNELS];
	logic signed [ACC_W-1:0] acc_q;

	logic [STEP_W-1:0] step_tab [KEYS];
	for (genvar k = 0; k < KEYS; k++) begin : g_step
		assign step_tab[k] = STEP_W'(step_val(k, TABLE_LENGTH));
	end

	logic accept;
	assign cmd.ready = (state_q == S_IDLE);
	assign accept = cmd.valid && cmd.ready;

	logic [VIDX_W-1:0] free_idx, match_idx;
	logic free_found, match_found;
	always_comb begin
		free_idx = '0;
		match_idx = '0;
		free_found = 1'b0;
		match_found = 1'b0;
		for (int v = NUM_VOICES - 1; v >= 0; v--) begin
			if (!active_q[v]) begin
				free_idx = VIDX_W'(v);
				free_found = 1'b1;
			end
			if (active_q[v] && note_q[v] == cmd.key) begin
				match_idx = VIDX_W'(v);
				match_found = 1'b1;
			end
		end
	end

	logic [CHI_W+CH_W-1:0] ch_ext;
	logic ch_ok;
	logic [WAVE_W-1:0] on_wave;
	assign ch_ext = (CHI_W+CH_W)'(cmd.channel);
	assign ch_ok = 32'(cmd.channel) < NUM_CHANNELS;
	assign on_wave = ch_ok ? chan_wave_q[ch_ext[CHI_W-1:0]] : WAVE_HYBRID;

	logic do_on, do_off, do_prog, do_tick;
	always_comb begin
		do_on = 1'b0;
		do_off = 1'b0;
		do_prog = 1'b0;
		do_tick = 1'b0;
		unique case (cmd.command)
			CMD_NOTE_ON: begin
				do_on = accept && cmd.velocity != '0 && free_found;
				do_off = accept && cmd.velocity == '0 && match_found;
			end
			CMD_NOTE_OFF: do_off = accept && match_found;
			CMD_PROGRAM: do_prog = accept && ch_ok;
			CMD_TICK: do_tick = accept;
			default: ;
		endcase
	end

	pws_ctl_t ctl_s1, ctl_s4;
	logic [VIDX_W-1:0] vidx_s1;
	logic [WORD_W-1:0] rdata, wb_data, mem_wdata, mem_wmask;
	logic wb_we, mem_we;
	logic [VIDX_W-1:0] wb_addr, mem_waddr;
	logic signed [SCALED_W-1:0] scaled_s4;

	assign mem_we = wb_we || do_on;
	assign mem_waddr = do_on ? free_idx : wb_addr;
	assign mem_wdata = do_on ? {cmd.velocity, step_tab[cmd.key], PHASE_W'(0), WSAMP_W'(0), on_wave}
	                         : wb_data;
	// keep the last sample of a voice taken over while it decays
	assign mem_wmask = (do_on && written_q[free_idx]) ? ~LAST_MASK : '1;

	pws_voice_mem #(.DEPTH(NUM_VOICES), .WIDTH(WORD_W)) u_mem (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.wmask(mem_wmask),
		.raddr(rd_idx_q),
		.rdata(rdata)
	);

	pws_voice_proc #(.NUM_VOICES(NUM_VOICES), .TABLE_LENGTH(TABLE_LENGTH)) u_proc (
		.clk(clk),
		.arst_n(arst_n),
		.ctl_s1(ctl_s1),
		.vidx_s1(vidx_s1),
		.rdata(rdata),
		.wb_we(wb_we),
		.wb_addr(wb_addr),
		.wb_data(wb_data),
		.ctl_s4(ctl_s4),
		.scaled_s4(scaled_s4)
	);

	// voice flags and channel waveforms (the voice notes are registered below)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
			written_q <= '0;
			for (int c = 0; c < NUM_CHANNELS; c++) begin
				chan_wave_q[c] <= WAVE_HYBRID;
			end
		end else begin
			if (do_on) begin
				active_q[free_idx] <= 1'b1;
				written_q[free_idx] <= 1'b1;
			end
			if (do_off) begin
				active_q[match_idx] <= 1'b0;
			end
			if (do_prog) begin
				chan_wave_q[ch_ext[CHI_W-1:0]] <= prog_wave(cmd.program_req);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_on) begin
			note_q[free_idx] <= cmd.key;
		end
		vidx_s1 <= rd_idx_q;
		if (do_tick) begin
			acc_q <= '0;
		end else if (ctl_s4.valid) begin
			acc_q <= acc_q + ACC_W'(scaled_s4);
		end
	end

	logic signed [ACC_W-1:0] acc_neg, acc_div, mixed;
	logic [SAMPLE_W-1:0] mix_out;
	always_comb begin
		acc_neg = -acc_q;
		acc_div = (acc_q < 0) ? -(acc_neg >>> MIX_SHIFT) : (acc_q >>> MIX_SHIFT);
		mixed = acc_div + MID_S;
		if (mixed > MAX_S) begin
			mix_out = SAMPLE_W'(SAMPLE_MAX);
		end else if (mixed < 0) begin
			mix_out = '0;
		end else begin
			mix_out = mixed[SAMPLE_W-1:0];
		end
	end

	logic res_load;
	assign res_load = (state_q == S_FIN) && (!res_valid_q || result.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rd_idx_q <= '0;
			ctl_s1 <= '0;
			res_valid_q <= 1'b0;
			res_sample_q <= '0;
		end else begin
			if (res_load) begin
				res_valid_q <= 1'b1;
				res_sample_q <= mix_out;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					ctl_s1 <= '0;
					rd_idx_q <= '0;
					if (do_tick) begin
						state_q <= S_TICK;
					end
				end
				S_TICK: begin
					ctl_s1 <= '{valid: 1'b1, last: rd_idx_q == VIDX_LAST,
					            active: active_q[rd_idx_q], written: written_q[rd_idx_q]};
					if (rd_idx_q == VIDX_LAST) begin
						state_q <= S_DRAIN;
					end else begin
						rd_idx_q <= rd_idx_q + VIDX_W'(1);
					end
				end
				S_DRAIN: begin
					ctl_s1 <= '0;
					if (ctl_s4.valid && ctl_s4.last) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					ctl_s1 <= '0;
					if (res_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					ctl_s1 <= '0;
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign result.valid = res_valid_q;
	assign result.sample = res_sample_q;

	`PWS_ASSERT(a_pipe_busy, clk, arst_n, ctl_s4.valid |-> (state_q != S_IDLE), "voice in flight while idle")
	`PWS_ASSERT_NEXT(a_last_fin, clk, arst_n, ctl_s4.valid && ctl_s4.last, state_q == S_FIN, "mix not finished after last voice")
	`PWS_ASSERT(a_active_written, clk, arst_n, (active_q & ~written_q) == '0, "active voice never written")
endmodule
`default_nettype wire

FILE: tb/tb_polyphonic_wavetable_synth.sv
`timescale 1ns / 1ps
// Self-checking testbench of the wavetable synthesiser: directed and random command streams.
// Depends on pws_pkg, pws_if and polyphonic_wavetable_synth; predicts every mixed sample.
module tb_polyphonic_wavetable_synth;
	import pws_pkg::*;

	localparam int VOICES = 15;
	localparam int TLEN = 100;
	localparam int CHANS = 16;
	localparam logic [31:0] PHASE_WRAP = 32'(TLEN) << 16;
	localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
	localparam logic [63:0] ONE_Q60 = 64'd1 << 60;
	localparam int STALL_LIMIT = 2000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	pws_cmd_if cmd_ch();
	pws_sample_if smp_ch();

	polyphonic_wavetable_synth dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_ch),
		.result(smp_ch)
	);

	always #2 clk = ~clk;

	logic [31:0] key_step[KEYS];
	logic signed [15:0] sine_tab[TLEN];
	logic signed [15:0] square_tab[TLEN];
	logic signed [15:0] hybrid_tab[TLEN];

	logic v_on[VOICES];
	logic [KEY_W-1:0] v_key[VOICES];
	logic [VEL_W-1:0] v_vol[VOICES];
	logic [31:0] v_step[VOICES];
	logic [31:0] v_phase[VOICES];
	int v_last[VOICES];
	logic [WAVE_W-1:0] v_wave[VOICES];
	logic [WAVE_W-1:0] ch_wave[CHANS];

	logic [SAMPLE_W-1:0] expected_samples[$];
	int errors = 0;
	int commands_sent = 0;
	int samples_seen = 0;
	int quiet_cycles = 0;
	logic steady = 1'b0;

	function automatic logic [63:0] mul_shr(logic [63:0] a, logic [63:0] b, int sh);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return 64'(p >> sh);
	endfunction

	function automatic logic [63:0] quarter_trig(logic [63:0] phi, bit cosine);
		logic [63:0] phi2;
		logic [63:0] term;
		logic [63:0] n;
		longint sum;
		phi2 = mul_shr(phi, phi, 60);
		term = cosine ? ONE_Q60 : phi;
		sum = longint'(term);
		n = cosine ? 64'd1 : 64'd2;
		for (int i = 1; i < 16; i++) begin
			term = mul_shr(term, phi2, 60) / (n * (n + 64'd1));
			n = n + 64'd2;
			if (i & 1) sum = sum - longint'(term);
			else sum = sum + longint'(term);
		end
		if (sum < 0) sum = 0;
		if (64'(sum) > ONE_Q60) sum = longint'(ONE_Q60);
		return 64'(sum);
	endfunction

	task automatic build_tables();
		logic [511:0] den, rhs, lhs;
		logic [31:0] m, t;
		logic [63:0] qpi, rpi, phi, s, ad, t2u;
		int quad, r, mag, d;
		longint t1, t2, tot;
		bit neg;
		den = 512'd1;
		for (int i = 0; i < 12; i++) den = den * 512'd375;
		for (int k = 0; k < KEYS; k++) begin
			rhs = 512'd1;
			for (int i = 0; i < 12; i++) rhs = rhs * 512'd1100;
			rhs = rhs << (111 + k);
			m = 0;
			for (int b = 25; b >= 0; b--) begin
				t = m | (32'd1 << b);
				lhs = den;
				for (int i = 0; i < 12; i++) lhs = lhs * {480'd0, t};
				if (lhs <= rhs) m = t;
			end
			key_step[k] = m;
		end
		qpi = (PI_Q60 >> 1) / 64'(TLEN);
		rpi = (PI_Q60 >> 1) % 64'(TLEN);
		for (int x = 0; x < TLEN; x++) begin
			quad = (4 * x) / TLEN;
			r = 4 * x - quad * TLEN;
			phi = qpi * 64'(r) + (rpi * 64'(r)) / 64'(TLEN);
			s = quarter_trig(phi, (quad & 1) != 0);
			neg = quad >= 2;
			mag = int'(32'(mul_shr(64'd32767, s, 60)));
			t1 = longint'(mul_shr(64'd16383, s, 20));
			d = x - TLEN / 2;
			ad = 64'(d < 0 ? -d : d) * 64'd16383;
			t2u = ((ad / 64'(TLEN)) << 40) + (((ad % 64'(TLEN)) << 40) / 64'(TLEN));
			t2 = longint'(t2u);
			sine_tab[x] = 16'(neg ? -mag : mag);
			square_tab[x] = (x < TLEN / 2) ? -16'sd32767 : 16'sd32767;
			tot = (neg ? -t1 : t1) + (d < 0 ? -t2 : t2);
			hybrid_tab[x] = 16'(tot >= 0 ? (tot >>> 40) : -((-tot) >>> 40));
		end
	endtask

	function automatic int vol_scaled(int s, logic [VEL_W-1:0] vol);
		int p;
		p = s * int'({1'b0, vol});
		return p >= 0 ? (p >>> 4) : -((-p + 15) >>> 4);
	endfunction

	function automatic void release_voice(logic [KEY_W-1:0] k);
		for (int v = 0; v < VOICES; v++)
			if (v_on[v] && v_key[v] == k) begin
				v_on[v] = 1'b0;
				return;
			end
	endfunction

	function automatic logic [WAVE_W-1:0] wave_of_program(logic [PROG_W-1:0] p);
		if (p == PROG_W'(PROG_SQUARE)) return WAVE_SQUARE;
		if ((p >= PROG_W'(PROG_SINE_LO) && p <= PROG_W'(PROG_SINE_HI)) ||
		    (p >= PROG_W'(PROG_SINE2_LO) && p <= PROG_W'(PROG_SINE2_HI)))
			return WAVE_SINE;
		return WAVE_HYBRID;
	endfunction

	function automatic void predict_synth(logic [CMD_W-1:0] c, logic [CH_W-1:0] ch,
		logic [KEY_W-1:0] k, logic [VEL_W-1:0] vel, logic [PROG_W-1:0] p);
		int sum;
		int idx;
		if (c == CMD_NOTE_ON) begin
			if (vel == 0) begin
				release_voice(k);
				return;
			end
			for (int v = 0; v < VOICES; v++)
				if (!v_on[v]) begin
					v_key[v] = k;
					v_step[v] = key_step[k];
					v_phase[v] = 0;
					v_wave[v] = (int'(ch) < CHANS) ? ch_wave[ch] : WAVE_HYBRID;
					v_vol[v] = vel;
					v_on[v] = 1'b1;
					break;
				end
		end else if (c == CMD_NOTE_OFF) begin
			release_voice(k);
		end else if (c == CMD_PROGRAM) begin
			if (int'(ch) < CHANS) ch_wave[ch] = wave_of_program(p);
		end else begin
			sum = 0;
			for (int v = 0; v < VOICES; v++) begin
				if (v_on[v]) begin
					v_phase[v] = v_phase[v] + v_step[v];
					if (v_phase[v] >= PHASE_WRAP) v_phase[v] = v_phase[v] - PHASE_WRAP;
					idx = int'(v_phase[v] >> 16);
					if (idx >= TLEN) idx = TLEN - 1;
					if (v_wave[v] == WAVE_SINE) v_last[v] = sine_tab[idx];
					else if (v_wave[v] == WAVE_SQUARE) v_last[v] = square_tab[idx];
					else v_last[v] = hybrid_tab[idx];
					sum += vol_scaled(v_last[v], v_vol[v]);
				end else if (v_vol[v] != 0) begin
					sum += vol_scaled(v_last[v], v_vol[v]);
					v_vol[v] = v_vol[v] - 1'b1;
				end
			end
			sum = sum / 1024 + MIX_MID;
			if (sum > SAMPLE_MAX) sum = SAMPLE_MAX;
			else if (sum < 0) sum = 0;
			expected_samples.push_back(SAMPLE_W'(sum));
		end
	endfunction

	function automatic bit idle_now();
		return !steady && ($urandom_range(99) < 32);
	endfunction

	task automatic send_command(logic [CMD_W-1:0] c, logic [CH_W-1:0] ch,
		logic [KEY_W-1:0] k, logic [VEL_W-1:0] vel, logic [PROG_W-1:0] p);
		@(negedge clk);
		while (idle_now()) begin
			cmd_ch.valid <= 1'b0;
			@(negedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.command <= c;
		cmd_ch.channel <= ch;
		cmd_ch.key <= k;
		cmd_ch.velocity <= vel;
		cmd_ch.program_req <= p;
		do @(posedge clk); while (!cmd_ch.ready);
		predict_synth(c, ch, k, vel, p);
		commands_sent++;
	endtask

	task automatic tick();
		send_command(CMD_TICK, 4'($urandom), 7'($urandom), 7'($urandom), 7'($urandom));
	endtask

	task automatic test_program_changes();
		logic [PROG_W-1:0] progs[10] = '{29, 71, 79, 52, 54, 70, 80, 0, 127, 51};
		foreach (progs[i]) send_command(CMD_PROGRAM, 4'(i), 7'd0, 7'd0, progs[i]);
		send_command(CMD_PROGRAM, 4'd15, 7'h7F, 7'h7F, 7'd29);
	endtask

	task automatic test_note_extremes();
		send_command(CMD_NOTE_ON, 4'd0, 7'd0, 7'd127, 7'h7F);
		send_command(CMD_NOTE_ON, 4'd1, 7'd127, 7'd1, 7'd0);
		send_command(CMD_NOTE_ON, 4'd15, 7'd69, 7'd127, 7'd0);
		send_command(CMD_NOTE_ON, 4'd2, 7'd69, 7'd64, 7'd0);
		tick();
		tick();
		send_command(CMD_NOTE_OFF, 4'd0, 7'd69, 7'd0, 7'd0);
		send_command(CMD_NOTE_ON, 4'd0, 7'd127, 7'd0, 7'd0);
		send_command(CMD_NOTE_OFF, 4'd0, 7'd50, 7'd0, 7'd0);
		tick();
		tick();
	endtask

	task automatic test_voice_exhaustion();
		for (int i = 0; i < 16; i++)
			send_command(CMD_NOTE_ON, 4'(i), 7'(60 + i), 7'd127, 7'd0);
		tick();
		for (int i = 0; i < 16; i++)
			send_command(CMD_NOTE_OFF, 4'(i), 7'(60 + i), 7'd0, 7'd0);
		send_command(CMD_NOTE_OFF, 4'd0, 7'd0, 7'd0, 7'd0);
		send_command(CMD_NOTE_OFF, 4'd0, 7'd69, 7'd0, 7'd0);
		send_command(CMD_NOTE_ON, 4'd3, 7'd40, 7'd90, 7'd0);
		for (int i = 0; i < 6; i++) tick();
	endtask

	task automatic test_random_traffic(int count);
		int r;
		logic [KEY_W-1:0] k;
		for (int n = 0; n < count; n++) begin
			steady = (n >= count / 3) && (n < count / 2);
			r = $urandom_range(99);
			k = (r & 1) ? 7'($urandom_range(127)) : 7'($urandom_range(72, 48));
			if (r < 40) tick();
			else if (r < 70)
				send_command(CMD_NOTE_ON, 4'($urandom), k, 7'($urandom_range(127, 1)),
					7'($urandom));
			else if (r < 85)
				send_command(CMD_NOTE_OFF, 4'($urandom), k, 7'($urandom), 7'($urandom));
			else if (r < 93)
				send_command(CMD_PROGRAM, 4'($urandom), 7'($urandom), 7'($urandom),
					($urandom_range(1)) ? 7'($urandom) : 7'($urandom_range(80, 28)));
			else
				send_command(2'($urandom), 4'($urandom), 7'($urandom), 7'($urandom & 1),
					7'($urandom));
		end
		steady = 1'b0;
	endtask

	always @(negedge clk) begin
		if (arst_n) smp_ch.ready <= !idle_now();
	end

	always @(posedge clk) begin
		if (arst_n && smp_ch.valid && smp_ch.ready) begin
			samples_seen++;
			if (expected_samples.size() == 0) begin
				$display("%0t: sample %0d with none expected", $realtime, smp_ch.sample);
				errors++;
			end else begin
				if (smp_ch.sample !== expected_samples[0]) begin
					$display("%0t: sample expected %0d actual %0d", $realtime,
						expected_samples[0], smp_ch.sample);
					errors++;
				end
				void'(expected_samples.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if ((cmd_ch.valid && cmd_ch.ready) || (smp_ch.valid && smp_ch.ready) || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $realtime, STALL_LIMIT);
			$display("** polyphonic_wavetable_synth: FAILED **");
			$finish;
		end
	end

	initial begin
		cmd_ch.valid = 1'b0;
		cmd_ch.command = CMD_TICK;
		cmd_ch.channel = '0;
		cmd_ch.key = '0;
		cmd_ch.velocity = '0;
		cmd_ch.program_req = '0;
		smp_ch.ready = 1'b0;
		for (int v = 0; v < VOICES; v++) begin
			v_on[v] = 1'b0;
			v_key[v] = '0;
			v_vol[v] = '0;
			v_step[v] = '0;
			v_phase[v] = '0;
			v_last[v] = 0;
			v_wave[v] = WAVE_HYBRID;
		end
		for (int c = 0; c < CHANS; c++) ch_wave[c] = WAVE_HYBRID;
		build_tables();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_program_changes();
		test_note_extremes();
		test_voice_exhaustion();
		test_random_traffic(1000);
		@(negedge clk);
		cmd_ch.valid <= 1'b0;
		while (expected_samples.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		$display("Sent %0d commands (note on/off, program change, tick) and checked %0d samples.",
			commands_sent, samples_seen);
		if (errors == 0 && expected_samples.size() == 0) begin
			$display("** polyphonic_wavetable_synth: PASSED **");
		end else begin
			$display("%0d mismatches", errors);
			$display("** polyphonic_wavetable_synth: FAILED **");
		end
		$finish;
	end
endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/pws_pkg.sv
hw/rtl/pws_if.sv
hw/rtl/pws_voice_mem.sv
hw/rtl/pws_voice_proc.sv
hw/rtl/polyphonic_wavetable_synth.sv
tb/tb_polyphonic_wavetable_synth.sv
